[hdl/iirl_pkg.sv]
// shared types and constants of the indexed insert/remove list
package iirl_pkg;

  // default sizes
  localparam int unsigned CapacityDef  = 64;
  localparam int unsigned DataWidthDef = 32;

  // fixed field widths of the stream beats
  localparam int unsigned KindW   = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  // request kinds
  typedef enum logic [KindW-1:0] {
    KIND_GET    = 3'd0,
    KIND_SET    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_APPEND = 3'd3,
    KIND_REMOVE = 3'd4
  } kind_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // what every cell does on an accepted beat
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } cell_op_e;

  // decoded request, from the decoder to the top level
  typedef struct packed {
    cell_op_e op;
    status_e  status;
    logic     rd_en;
    logic     inc;
    logic     dec;
  } ctrl_t;

endpackage

[hdl/iirl_cell.sv]
// one list entry: holds a word and shifts to or from its neighbours
module iirl_cell #(
  parameter int unsigned DATA_WIDTH = iirl_pkg::DataWidthDef,
  parameter int unsigned CMP_W      = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  iirl_pkg::cell_op_e    op_i,
  input  logic [CMP_W-1:0]      pos_i,
  input  logic [CMP_W-1:0]      cnt_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] q_o,
  output logic [DATA_WIDTH-1:0] rd_o
);
  import iirl_pkg::*;

  localparam logic [CMP_W-1:0] MyIdx  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] MyIdx1 = CMP_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  load;

  // pick the new contents from the word, the lower or the upper neighbour
  always_comb begin
    load   = 1'b0;
    data_d = data_q;
    case (op_i)
      OP_SET: begin
        if (MyIdx == pos_i) begin
          load   = 1'b1;
          data_d = word_i;
        end
      end
      OP_INSERT: begin
        if (MyIdx == pos_i) begin
          load   = 1'b1;
          data_d = word_i;
        end else if (MyIdx > pos_i && MyIdx <= cnt_i) begin
          load   = 1'b1;
          data_d = prev_i;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_i && MyIdx1 < cnt_i) begin
          load   = 1'b1;
          data_d = next_i;
        end
      end
      default: begin
        load   = 1'b0;
        data_d = data_q;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (en_i && load) begin
      data_q <= data_d;
    end
  end

  assign q_o  = data_q;
  // read tap, zero unless this cell is addressed
  assign rd_o = (MyIdx == pos_i) ? data_q : '0;

endmodule

[hdl/iirl_ctrl.sv]
// request decoder: range and full checks, cell operation and count change
module iirl_ctrl #(
  parameter int unsigned CAPACITY = iirl_pkg::CapacityDef,
  parameter int unsigned CMP_W    = 7
) (
  input  iirl_pkg::kind_e   kind_i,
  input  logic [CMP_W-1:0]  pos_i,
  input  logic [CMP_W-1:0]  cnt_i,
  output logic [CMP_W-1:0]  cell_pos_o,
  output iirl_pkg::ctrl_t   ctrl_o
);
  import iirl_pkg::*;

  logic full;
  logic in_range;

  assign full     = (cnt_i >= CMP_W'(CAPACITY));
  assign in_range = (pos_i < cnt_i);

  // decode one request
  always_comb begin
    ctrl_o     = '{op: OP_HOLD, status: ST_OK, rd_en: 1'b0, inc: 1'b0, dec: 1'b0};
    cell_pos_o = pos_i;
    case (kind_i)
      KIND_GET: begin
        if (in_range) ctrl_o.rd_en = 1'b1;
        else          ctrl_o.status = ST_RANGE;
      end
      KIND_SET: begin
        if (in_range) ctrl_o.op = OP_SET;
        else          ctrl_o.status = ST_RANGE;
      end
      KIND_INSERT: begin
        if (full) begin
          ctrl_o.status = ST_FULL;
        end else if (pos_i > cnt_i) begin
          ctrl_o.status = ST_RANGE;
        end else begin
          ctrl_o.op  = OP_INSERT;
          ctrl_o.inc = 1'b1;
        end
      end
      KIND_APPEND: begin
        // append is an insert at the end of the list
        cell_pos_o = cnt_i;
        if (full) begin
          ctrl_o.status = ST_FULL;
        end else begin
          ctrl_o.op  = OP_INSERT;
          ctrl_o.inc = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (in_range) begin
          ctrl_o.op    = OP_REMOVE;
          ctrl_o.rd_en = 1'b1;
          ctrl_o.dec   = 1'b1;
        end else begin
          ctrl_o.status = ST_RANGE;
        end
      end
      default: begin
        ctrl_o.op = OP_HOLD;
      end
    endcase
  end

endmodule

[hdl/indexed_insert_remove_list.sv]
// top level of the indexed insert/remove list
//
// A bounded ordered list of words kept in a row of cells, one per entry.
// Requests arrive as beats on the s_axis channel: tuser carries the kind
// (get, set, insert, append, remove), tdata the position and the word.
// Each request gives exactly one result beat on m_axis: tdata carries the
// word read (get, remove; zero otherwise) and the new live count, tuser the
// status (ok, position out of range, list full).
// The result is valid in the cycle after the request is accepted, and a
// request is taken every cycle unless the result is stalled: all cells
// shift together in the cycle the request is accepted, and the read word
// is picked from the cells through a one-hot OR over the row.
// A result waits in the output register while m_axis_tready is low; a new
// request is taken only when that register is empty or being emptied.
// Reset clears the live count and the output valid; the entry contents are
// left as they are and are not readable until written again.
module indexed_insert_remove_list #(
  parameter int unsigned CAPACITY   = iirl_pkg::CapacityDef,
  parameter int unsigned DATA_WIDTH = iirl_pkg::DataWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] position, [37:6] data_in, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] data_out, [38:32] count, [39] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import iirl_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CntW > PosW) ? CntW : PosW;

  logic                  accept;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CMP_W-1:0]      cnt_cmp;
  logic [CMP_W-1:0]      req_pos;
  logic [CMP_W-1:0]      cell_pos;
  logic [DATA_WIDTH-1:0] req_word;
  kind_e                 req_kind;
  ctrl_t                 ctrl;
  cell_op_e              cell_op;
  logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;
  logic                  out_valid_q;
  logic [WordW-1:0]      out_data_q;
  logic [CountW-1:0]     out_cnt_q;
  status_e               out_status_q;

  // input beat fields
  assign req_kind = kind_e'(s_axis_tuser);
  assign req_pos  = CMP_W'(s_axis_tdata[PosW-1:0]);
  assign req_word = DATA_WIDTH'(s_axis_tdata[PosW +: WordW]);
  assign cnt_cmp  = CMP_W'(cnt_q);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  iirl_ctrl #(
    .CAPACITY (CAPACITY),
    .CMP_W    (CMP_W)
  ) u_ctrl (
    .kind_i     (req_kind),
    .pos_i      (req_pos),
    .cnt_i      (cnt_cmp),
    .cell_pos_o (cell_pos),
    .ctrl_o     (ctrl)
  );

  assign cell_op = accept ? ctrl.op : OP_HOLD;

  // row of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = cell_q[g+1];
    end
    iirl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CMP_W      (CMP_W),
      .IDX        (g)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (accept),
      .op_i   (cell_op),
      .pos_i  (cell_pos),
      .cnt_i  (cnt_cmp),
      .word_i (req_word),
      .prev_i (prev_w),
      .next_i (next_w),
      .q_o    (cell_q[g]),
      .rd_o   (cell_rd[g])
    );
  end

  // one-hot OR of the cell read taps
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // live count update
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.inc)      cnt_d = cnt_q + CntW'(1);
    else if (ctrl.dec) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= ctrl.rd_en ? WordW'(rd_word) : '0;
      out_cnt_q    <= CountW'(cnt_d);
      out_status_q <= ctrl.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_cnt_q, out_data_q};
  assign m_axis_tuser  = out_status_q;

endmodule

[bench/indexed_insert_remove_list_tb.sv]
// self-checking stream testbench for the indexed insert/remove list
module indexed_insert_remove_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iirl_pkg::*;

  // one expected result beat
  typedef struct {
    logic [WordW-1:0]   word;
    status_e            status;
    logic [CountW-1:0]  count;
  } reply_t;

  // shadow copy of the list, predicts the reply to every accepted request
  class list_shadow;
    logic [WordW-1:0] cells [CapacityDef];
    int unsigned      live;
    reply_t           pending_replies [$];
    int unsigned      errors;

    function new();
      live   = 0;
      errors = 0;
    endfunction

    // apply one accepted request and queue its reply
    function void take_request(logic [KindW-1:0] kind, logic [PosW-1:0] pos,
                               logic [WordW-1:0] word);
      reply_t r;
      r.word   = '0;
      r.status = ST_OK;
      case (kind)
        KIND_GET: begin
          if (pos < live) r.word = cells[pos];
          else r.status = ST_RANGE;
        end
        KIND_SET: begin
          if (pos < live) cells[pos] = word;
          else r.status = ST_RANGE;
        end
        KIND_INSERT: begin
          // full check comes before the position check
          if (live >= CapacityDef) begin
            r.status = ST_FULL;
          end else if (pos > live) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = live; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = word;
            live++;
          end
        end
        KIND_APPEND: begin
          if (live >= CapacityDef) begin
            r.status = ST_FULL;
          end else begin
            cells[live] = word;
            live++;
          end
        end
        KIND_REMOVE: begin
          if (pos < live) begin
            r.word = cells[pos];
            for (int i = pos; i + 1 < live; i++) cells[i] = cells[i+1];
            live--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: ;
      endcase
      r.count = CountW'(live);
      pending_replies.push_back(r);
    endfunction

    // compare one result beat with the oldest queued reply
    function void check_result(logic [WordW-1:0] word, logic [StatusW-1:0] status,
                               logic [CountW-1:0] count);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: data %h status %0d count %0d",
                 $time, word, status, count);
        return;
      end
      want = pending_replies.pop_front();
      if (word !== want.word) begin
        errors++;
        $display("%0t: data_out mismatch: expected %h actual %h", $time, want.word, word);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
      end
      if (count !== want.count) begin
        errors++;
        $display("%0t: count mismatch: expected %0d actual %0d", $time, want.count, count);
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [5:0] position, [37:6] data_in, [39:38] zero
  logic [39:0]       s_axis_tdata  = '0;
  // [2:0] kind
  logic [2:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [31:0] data_out, [38:32] count, [39] zero
  logic [39:0]       m_axis_tdata;
  // [1:0] status
  logic [1:0]        m_axis_tuser;

  list_shadow shadow = new();
  bit         feed_idle = 1'b1;

  indexed_insert_remove_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // offer one request beat, after a random gap while feed_idle is set, hold it until taken
  task automatic send_request(input logic [KindW-1:0] kind, input logic [PosW-1:0] pos,
                              input logic [WordW-1:0] word);
    int gap;
    gap = feed_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, word, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.take_request(kind, pos, word);
  endtask

  // result side: random stalls, one long hold-off to back the list up
  initial begin : result_sink
    int          gap;
    int unsigned seen;
    bit          stalling;
    seen     = 0;
    stalling = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (seen % 50 == 0) stalling = ($urandom_range(0, 2) != 0);
      if (seen == 400) gap = 300;
      else gap = stalling ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      shadow.check_result(m_axis_tdata[WordW-1:0], m_axis_tuser,
                          m_axis_tdata[WordW+CountW-1:WordW]);
      seen++;
    end
  end

  // stimulus and end of run
  initial begin : request_source
    int               mode;
    int               grow_pct;
    int               remove_pct;
    int               r;
    int               top;
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  pos;
    logic [WordW-1:0] word;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, both ends, middle, refusals, spare kinds
    send_request(KIND_REMOVE, '0, '0);
    send_request(KIND_GET,    '0, '0);
    send_request(KIND_SET,    '0, '1);
    send_request(KIND_INSERT, 6'd1, '1);
    send_request(KIND_INSERT, '1, 32'h1234_5678);
    send_request(KIND_APPEND, '0, '1);
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, 6'd2, 32'h8000_0001);
    send_request(KIND_INSERT, 6'd1, 32'h0123_4567);
    send_request(KIND_GET,    '0, '1);
    send_request(KIND_GET,    6'd3, '0);
    send_request(KIND_GET,    '1, '0);
    send_request(KIND_SET,    6'd3, 32'hA5A5_5A5A);
    send_request(KIND_SET,    6'd4, '1);
    send_request(KIND_GET,    6'd3, '0);
    send_request(KIND_REMOVE, 6'd3, '1);
    send_request(KIND_REMOVE, '0, '0);
    send_request(KIND_REMOVE, '1, '0);
    for (int k = int'(KIND_REMOVE) + 1; k < (1 << KindW); k++)
      send_request(KindW'(k), '1, '1);

    // random phases: mostly grow, mix, mostly drain
    for (int p = 0; p < 10; p++) begin
      mode      = p % 3;
      feed_idle = ($urandom_range(0, 3) != 0);
      grow_pct   = (mode == 0) ? 85 : (mode == 1) ? 40 : 20;
      remove_pct = (mode == 0) ? 5  : (mode == 1) ? 20 : 62;
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          kind = KindW'($urandom_range(int'(KIND_REMOVE) + 1, (1 << KindW) - 1));
        else if (r < 3 + grow_pct)
          kind = ($urandom_range(0, 1) != 0) ? KIND_INSERT : KIND_APPEND;
        else if (r < 3 + grow_pct + remove_pct)
          kind = KIND_REMOVE;
        else
          kind = ($urandom_range(0, 1) != 0) ? KIND_GET : KIND_SET;
        // mostly positions up to the live count, the boundary included
        top = (shadow.live < 63) ? shadow.live : 63;
        if ($urandom_range(0, 3) != 0) pos = PosW'($urandom_range(0, top));
        else pos = PosW'($urandom_range(0, 63));
        case ($urandom_range(0, 7))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        send_request(kind, pos, word);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then wait for any stray beat
    while (shadow.pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("indexed_insert_remove_list_tb: clean");
    end else begin
      $display("indexed_insert_remove_list_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #1_000_000;
    $display("indexed_insert_remove_list_tb: errors");
    $finish;
  end

endmodule

[sim.f]
hdl/iirl_pkg.sv
hdl/iirl_cell.sv
hdl/iirl_ctrl.sv
hdl/indexed_insert_remove_list.sv
bench/indexed_insert_remove_list_tb.sv
